// ===== hdl/rkf_pkg.sv =====
// ----------------------------------------------------------------------------
// rkf_pkg: shared types and constants of the RGB 3x3 kernel filter
// Holds the stream payloads, configuration registers, kernel codes and the
// fixed-point constants of the divide-by-144 step.
// ----------------------------------------------------------------------------
package rkf_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned PIX_W    = 3 * SAMPLE_W;
  localparam int unsigned CFG_W    = 13;
  localparam int unsigned CFG_IDX_W = 3;

  // Full scale of an 8.8 sample: 255.0
  localparam logic [SAMPLE_W-1:0] FULL_SCALE = 16'd65280;

  // Signed width of a per-plane kernel sum (coefficients scaled by 144)
  localparam int unsigned SUM_W = 28;
  // Rounding offset: half of 144
  localparam logic signed [SUM_W-1:0] ROUND_HALF = 28'sd72;
  // (sum + 72) / 16 fits this width, then divide by 9 with a reciprocal
  localparam int unsigned X_W = 23;
  localparam int unsigned RECIP_SHIFT = 26;
  localparam logic [X_W-1:0] RECIP_9 = 23'd7456541;  // ceil(2^26 / 9)
  localparam int unsigned PROD_W = 2 * X_W;
  localparam int unsigned Q_W = PROD_W - RECIP_SHIFT;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_SEL_LEFT      = 3'd2,
    REG_SEL_TOP       = 3'd3,
    REG_SEL_RIGHT     = 3'd4,
    REG_SEL_BOTTOM    = 3'd5,
    REG_WHOLE_IMAGE   = 3'd6,
    REG_KERNEL_SELECT = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    KERN_EDGE    = 2'd0,
    KERN_SHARPEN = 2'd1,
    KERN_BOX     = 2'd2,
    KERN_GAUSS   = 2'd3
  } kern_e;

  typedef struct packed {
    logic                 mode;
    logic [SAMPLE_W-1:0]  red_in;
    logic [SAMPLE_W-1:0]  green_in;
    logic [SAMPLE_W-1:0]  blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0]  red_out;
    logic [SAMPLE_W-1:0]  green_out;
    logic [SAMPLE_W-1:0]  blue_out;
    logic                 frame_end;
  } pix_out_t;

  typedef struct packed {
    logic [CFG_W-1:0] image_width;
    logic [CFG_W-1:0] image_height;
    logic [CFG_W-1:0] sel_left;
    logic [CFG_W-1:0] sel_top;
    logic [CFG_W-1:0] sel_right;
    logic [CFG_W-1:0] sel_bottom;
    logic             whole_image;
    kern_e            kernel_select;
  } cfg_t;

  // Classification of one beat, decided by the front part
  typedef struct packed {
    logic emit;   // beat releases a result
    logic filt;   // that result is filtered, else the center passes
    logic last;   // that result closes the frame
  } item_flags_t;

  localparam int unsigned FLAGS_W = $bits(item_flags_t);

endpackage

// ===== hdl/rkf_front.sv =====
// ----------------------------------------------------------------------------
// rkf_front: raster position tracking and beat classification
// Keeps the input and output raster counters, drops early drains and tags
// each kept beat with its line-store column and result flags.
// ----------------------------------------------------------------------------
module rkf_front
  import rkf_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096,
  localparam int unsigned AW = $clog2(MAX_WIDTH)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             accept_i,
  input  pix_in_t          data_i,
  output logic             push_o,
  output logic [PIX_W-1:0] pix_o,
  output logic [AW-1:0]    col_o,
  output item_flags_t      flags_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 2);
  localparam int unsigned MW = (CW > RW) ? CW : RW;
  localparam int unsigned XW = ((MW > CFG_W) ? MW : CFG_W) + 2;

  logic [RW-1:0] in_row_q, in_row_d, out_row_q, out_row_d;
  logic [CW-1:0] in_col_q, in_col_d, out_col_q, out_col_d;

  logic [XW-1:0] w, h, w_raw, h_raw;
  logic [XW-1:0] irow, icol, orow, ocol, icol_inc, ocol_inc;
  logic [XW-1:0] sl, st, sr, sb;
  logic          complete, drop, emit, last, interior, in_sel;

  always_comb begin
    w_raw = XW'(cfg_i.image_width);
    h_raw = XW'(cfg_i.image_height);
    if (w_raw == '0) begin
      w = XW'(1);
    end else if (w_raw > XW'(MAX_WIDTH)) begin
      w = XW'(MAX_WIDTH);
    end else begin
      w = w_raw;
    end
    if (h_raw == '0) begin
      h = XW'(1);
    end else if (h_raw > XW'(MAX_HEIGHT)) begin
      h = XW'(MAX_HEIGHT);
    end else begin
      h = h_raw;
    end
  end

  assign irow     = XW'(in_row_q);
  assign icol     = XW'(in_col_q);
  assign orow     = XW'(out_row_q);
  assign ocol     = XW'(out_col_q);
  assign icol_inc = icol + XW'(1);
  assign ocol_inc = ocol + XW'(1);

  assign complete = irow >= h;
  assign drop     = data_i.mode && !complete;
  assign emit     = (irow >= XW'(2)) || ((irow == XW'(1)) && (icol != '0));
  assign last     = (orow + XW'(1) >= h) && (ocol_inc >= w);

  // Selection bounds pulled in from any frame edge they touch
  always_comb begin
    sl = (cfg_i.sel_left == '0) ? XW'(1) : XW'(cfg_i.sel_left);
    st = (cfg_i.sel_top == '0) ? XW'(1) : XW'(cfg_i.sel_top);
    sr = (XW'(cfg_i.sel_right) == w) ? w - XW'(1) : XW'(cfg_i.sel_right);
    sb = (XW'(cfg_i.sel_bottom) == h) ? h - XW'(1) : XW'(cfg_i.sel_bottom);
  end

  assign interior = (orow >= XW'(1)) && (ocol >= XW'(1)) &&
                    (orow + XW'(2) <= h) && (ocol + XW'(2) <= w);
  assign in_sel   = (orow >= st) && (orow < sb) && (ocol >= sl) && (ocol < sr);

  assign push_o       = accept_i && !drop;
  assign pix_o        = complete ? '0 : {data_i.red_in, data_i.green_in, data_i.blue_in};
  assign col_o        = (icol < XW'(MAX_WIDTH)) ? in_col_q[AW-1:0] : AW'(MAX_WIDTH - 1);
  assign flags_o.emit = emit;
  assign flags_o.filt = interior && (cfg_i.whole_image || in_sel);
  assign flags_o.last = last;

  always_comb begin
    in_row_d  = in_row_q;
    in_col_d  = in_col_q;
    out_row_d = out_row_q;
    out_col_d = out_col_q;
    if (push_o) begin
      if (icol_inc >= w) begin
        in_col_d = '0;
        in_row_d = in_row_q + RW'(1);
      end else begin
        in_col_d = icol_inc[CW-1:0];
      end
      if (emit) begin
        if (last) begin
          in_row_d  = '0;
          in_col_d  = '0;
          out_row_d = '0;
          out_col_d = '0;
        end else if (ocol_inc >= w) begin
          out_col_d = '0;
          out_row_d = out_row_q + RW'(1);
        end else begin
          out_col_d = ocol_inc[CW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q  <= '0;
      in_col_q  <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
    end else begin
      in_row_q  <= in_row_d;
      in_col_q  <= in_col_d;
      out_row_q <= out_row_d;
      out_col_q <= out_col_d;
    end
  end

endmodule

// ===== hdl/rkf_queue.sv =====
// ----------------------------------------------------------------------------
// rkf_queue: short FIFO between the front and back parts
// Lets the front keep accepting while the back holds, and the reverse.
// ----------------------------------------------------------------------------
module rkf_queue
  import rkf_pkg::*;
#(
  parameter int unsigned DW    = 64,
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] data_i,
  input  logic          pop_i,
  output logic          valid_o,
  output logic          full_o,
  output logic [DW-1:0] data_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  logic [DW-1:0] entry_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [NW-1:0] cnt_q, cnt_d;

  assign valid_o = cnt_q != '0;
  assign full_o  = cnt_q == NW'(DEPTH);
  assign data_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    priority if (push_i && !pop_i) begin
      cnt_d = cnt_q + NW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== hdl/rkf_back.sv =====
// ----------------------------------------------------------------------------
// rkf_back: line stores, 3x3 window and kernel arithmetic
// Pipelined: line-store read, window shift, tap sums, kernel sum,
// reciprocal multiply, correction and clamp into the output register.
// ----------------------------------------------------------------------------
module rkf_back
  import rkf_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 4096,
  localparam int unsigned AW = $clog2(MAX_WIDTH)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  kern_e            kern_i,
  input  logic             q_valid_i,
  input  logic [PIX_W-1:0] q_pix_i,
  input  logic [AW-1:0]    q_col_i,
  input  item_flags_t      q_flags_i,
  output logic             pop_o,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output pix_out_t         out_data_o
);

  localparam int unsigned TAP_SUM_W = SAMPLE_W + 2;

  // Line store entry: upper row over middle row of one column
  logic [2*PIX_W-1:0] mem_q [MAX_WIDTH];
  logic [2*PIX_W-1:0] rdata_q, fwd_data_q, line_eff, wdata;
  logic               fwd_hit_q;

  logic               en;
  logic               v_ld_q, v_sum_q, v_ker_q, v_mul_q, out_valid_q;
  logic [PIX_W-1:0]   pix_ld_q;
  logic [AW-1:0]      col_ld_q;
  item_flags_t        fl_ld_q, fl_win_q, fl_sum_q, fl_ker_q, fl_mul_q;
  logic               v_win_q;
  logic [PIX_W-1:0]   win_q [9];
  logic [PIX_W-1:0]   ctr_sum_q, ctr_ker_q, ctr_mul_q;
  pix_out_t           out_q;

  logic [SAMPLE_W-1:0] res [3];

  assign en    = !out_valid_q || !out_stall_i;
  assign pop_o = en && q_valid_i;

  assign line_eff = fwd_hit_q ? fwd_data_q : rdata_q;
  assign wdata    = {line_eff[PIX_W-1:0], pix_ld_q};

  // Line store: one read and one write per advance
  always_ff @(posedge clk_i) begin
    if (en && v_ld_q) begin
      mem_q[col_ld_q] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rdata_q    <= mem_q[q_col_i];
      fwd_data_q <= wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q   <= 1'b0;
      v_ld_q      <= 1'b0;
      v_win_q     <= 1'b0;
      v_sum_q     <= 1'b0;
      v_ker_q     <= 1'b0;
      v_mul_q     <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else if (en) begin
      // Same column written now as read now: forward the written data in place of the read
      fwd_hit_q   <= v_ld_q && (col_ld_q == q_col_i);
      v_ld_q      <= q_valid_i;
      v_win_q     <= v_ld_q && fl_ld_q.emit;
      v_sum_q     <= v_win_q;
      v_ker_q     <= v_sum_q;
      v_mul_q     <= v_ker_q;
      out_valid_q <= v_mul_q;
      if (v_ld_q) begin
        win_q[0] <= win_q[1];
        win_q[1] <= win_q[2];
        win_q[2] <= line_eff[2*PIX_W-1:PIX_W];
        win_q[3] <= win_q[4];
        win_q[4] <= win_q[5];
        win_q[5] <= line_eff[PIX_W-1:0];
        win_q[6] <= win_q[7];
        win_q[7] <= win_q[8];
        win_q[8] <= pix_ld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pix_ld_q  <= q_pix_i;
      col_ld_q  <= q_col_i;
      fl_ld_q   <= q_flags_i;
      fl_win_q  <= fl_ld_q;
      fl_sum_q  <= fl_win_q;
      ctr_sum_q <= win_q[4];
      fl_ker_q  <= fl_sum_q;
      ctr_ker_q <= ctr_sum_q;
      fl_mul_q  <= fl_ker_q;
      ctr_mul_q <= ctr_ker_q;
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_plane
    localparam int unsigned LSB = PIX_W - SAMPLE_W * (g + 1);

    logic [SAMPLE_W-1:0]     c_q;
    logic [TAP_SUM_W-1:0]    sides_q, corners_q;
    logic signed [SUM_W-1:0] c_s, s_s, k_s, t, sum_d, sum_q, rnd;
    logic [X_W-1:0]          x, x_q;
    logic [PROD_W-1:0]       prod_q;
    logic                    pos_q;
    logic [Q_W-1:0]          q0, q;
    logic [Q_W+3:0]          q0x9;

    always_ff @(posedge clk_i) begin
      if (en) begin
        c_q       <= win_q[4][LSB +: SAMPLE_W];
        sides_q   <= TAP_SUM_W'(win_q[1][LSB +: SAMPLE_W]) +
                     TAP_SUM_W'(win_q[3][LSB +: SAMPLE_W]) +
                     TAP_SUM_W'(win_q[5][LSB +: SAMPLE_W]) +
                     TAP_SUM_W'(win_q[7][LSB +: SAMPLE_W]);
        corners_q <= TAP_SUM_W'(win_q[0][LSB +: SAMPLE_W]) +
                     TAP_SUM_W'(win_q[2][LSB +: SAMPLE_W]) +
                     TAP_SUM_W'(win_q[6][LSB +: SAMPLE_W]) +
                     TAP_SUM_W'(win_q[8][LSB +: SAMPLE_W]);
      end
    end

    // Kernels x144 reduced to shift-and-add on center, sides and corners
    always_comb begin
      c_s = $signed(SUM_W'(c_q));
      s_s = $signed(SUM_W'(sides_q));
      k_s = $signed(SUM_W'(corners_q));
      unique case (kern_i)
        KERN_EDGE: begin
          t     = (c_s <<< 3) - s_s - k_s;
          sum_d = (t <<< 7) + (t <<< 4);
        end
        KERN_SHARPEN: begin
          t     = (c_s <<< 2) + c_s - s_s;
          sum_d = (t <<< 7) + (t <<< 4);
        end
        KERN_BOX: begin
          t     = c_s + s_s + k_s;
          sum_d = t <<< 4;
        end
        KERN_GAUSS: begin
          t     = (c_s <<< 2) + (s_s <<< 1) + k_s;
          sum_d = (t <<< 3) + t;
        end
        default: begin
          t     = '0;
          sum_d = '0;
        end
      endcase
    end

    assign rnd = sum_q + ROUND_HALF;
    assign x   = rnd[X_W+3:4];

    always_ff @(posedge clk_i) begin
      if (en) begin
        sum_q  <= sum_d;
        pos_q  <= sum_q > 0;
        x_q    <= x;
        prod_q <= PROD_W'(x) * PROD_W'(RECIP_9);
      end
    end

    // Reciprocal estimate is at most one high: step back when it overshoots
    assign q0   = prod_q[RECIP_SHIFT +: Q_W];
    assign q0x9 = {q0, 3'b000} + (Q_W+4)'(q0);
    assign q    = (q0x9 > (Q_W+4)'(x_q)) ? q0 - Q_W'(1) : q0;

    always_comb begin
      if (!pos_q) begin
        res[g] = '0;
      end else if (q > Q_W'(FULL_SCALE)) begin
        res[g] = FULL_SCALE;
      end else begin
        res[g] = q[SAMPLE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.red_out   <= fl_mul_q.filt ? res[0] : ctr_mul_q[PIX_W-1 -: SAMPLE_W];
      out_q.green_out <= fl_mul_q.filt ? res[1] : ctr_mul_q[PIX_W-SAMPLE_W-1 -: SAMPLE_W];
      out_q.blue_out  <= fl_mul_q.filt ? res[2] : ctr_mul_q[SAMPLE_W-1:0];
      out_q.frame_end <= fl_mul_q.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hdl/rgb_3x3_kernel_filter.sv =====
// ----------------------------------------------------------------------------
// rgb_3x3_kernel_filter: 3x3 kernel filter over an RGB raster stream
// Top level: configuration registers, front classifier, queue, back pipeline.
// ----------------------------------------------------------------------------
// Takes one RGB pixel (three unsigned 8.8 samples) per clock in raster order
// and returns one result per clock once the window is primed and no stall
// holds it: sustained rate is one beat per cycle, set by the single read plus
// single write per cycle on the combined line store (one entry per column,
// MAX_WIDTH deep). The first result of a frame is released by input beat
// image_width+2; drain beats (mode = 1) push out the remaining image_width+1
// results at the frame tail, and a drain sent before the frame is complete
// is dropped, and a valid result is held in place while out_stall_i is high.
// Pixels inside the filter region get the selected kernel (edge, sharpen,
// box, gaussian) per plane, rounded to nearest and clamped to 0..255.0; all
// others pass unchanged. frame_end marks the result of the last pixel.
// Write configuration only while the block is idle. No clearing pass is run:
// line-store entries are always written before their data reaches a result.
// ----------------------------------------------------------------------------
module rgb_3x3_kernel_filter
  import rkf_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  // input pixel channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  pix_in_t              in_data_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output pix_out_t             out_data_o
);

  localparam int unsigned AW      = $clog2(MAX_WIDTH);
  localparam int unsigned QDW     = FLAGS_W + AW + PIX_W;
  localparam int unsigned Q_DEPTH = 4;

  cfg_t             cfg_q;
  logic             accept, q_push, q_pop, q_valid, q_full;
  logic [PIX_W-1:0] f_pix;
  logic [AW-1:0]    f_col;
  item_flags_t      f_flags;
  logic [QDW-1:0]   q_rd;

  // Register writes; kernel code stored as given
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width   <= 13'd4096;
      cfg_q.image_height  <= 13'd4096;
      cfg_q.sel_left      <= '0;
      cfg_q.sel_top       <= '0;
      cfg_q.sel_right     <= 13'd4096;
      cfg_q.sel_bottom    <= 13'd4096;
      cfg_q.whole_image   <= 1'b1;
      cfg_q.kernel_select <= KERN_EDGE;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_IMAGE_WIDTH:   cfg_q.image_width   <= cfg_wdata_i;
        REG_IMAGE_HEIGHT:  cfg_q.image_height  <= cfg_wdata_i;
        REG_SEL_LEFT:      cfg_q.sel_left      <= cfg_wdata_i;
        REG_SEL_TOP:       cfg_q.sel_top       <= cfg_wdata_i;
        REG_SEL_RIGHT:     cfg_q.sel_right     <= cfg_wdata_i;
        REG_SEL_BOTTOM:    cfg_q.sel_bottom    <= cfg_wdata_i;
        REG_WHOLE_IMAGE:   cfg_q.whole_image   <= cfg_wdata_i[0];
        REG_KERNEL_SELECT: cfg_q.kernel_select <= kern_e'(cfg_wdata_i[1:0]);
        default: ;
      endcase
    end
  end

  // Stall the input only when the queue is full
  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  rkf_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .accept_i (accept),
    .data_i   (in_data_i),
    .push_o   (q_push),
    .pix_o    (f_pix),
    .col_o    (f_col),
    .flags_o  (f_flags)
  );

  rkf_queue #(
    .DW    (QDW),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  ({f_flags, f_col, f_pix}),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .full_o  (q_full),
    .data_o  (q_rd)
  );

  rkf_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .kern_i      (cfg_q.kernel_select),
    .q_valid_i   (q_valid),
    .q_pix_i     (q_rd[PIX_W-1:0]),
    .q_col_i     (q_rd[PIX_W +: AW]),
    .q_flags_i   (item_flags_t'(q_rd[QDW-1 -: FLAGS_W])),
    .pop_o       (q_pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  // Never push into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(q_push && q_full))
    else $error("push into full queue");
  // Pop only a valid head entry
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> q_valid)
    else $error("pop from empty queue");
  // A held result keeps the back pipeline from popping
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !q_pop)
    else $error("pop while result held");
`endif

endmodule
